[hw/rtl/plpc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pointer-keyed linear probe cache package
// Shared widths, request codes, result flags and sequencer states.
// ----------------------------------------------------------------------------
package plpc_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 256;
    localparam int unsigned KEY_W           = 64;
    localparam int unsigned VAL_W           = 64;
    localparam int unsigned HASH_SHIFT_LO   = 4;
    localparam int unsigned HASH_SHIFT_HI   = 12;
    // Bytes of the hash that are folded into the home slot sum.
    localparam int unsigned HASH_BYTES      = KEY_W / 8;
    // Steps spent reducing the hash to a home slot when the depth is not a power of two.
    localparam int unsigned HASH_STEPS      = 3;

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_CLEAR  = 1'b1;

    typedef struct packed {
        logic table_full;
        logic was_stored;
        logic was_hit;
        logic value_present;
    } t_flags;

    localparam int unsigned FLAGS_W = $bits(t_flags);

    typedef struct packed {
        logic             used;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_ISSUE,
        S_CHECK
    } t_state;

endpackage : plpc_pkg
`default_nettype wire

[hw/rtl/pointer_keyed_linear_probe_cache.sv]
`timescale 1ns / 1ps
`default_nettype none
// A lookup goes from acceptance to S_ISSUE, which reads the home slot, and to S_CHECK, which
// registers the result or reads the next slot; when TABLE_DEPTH is not a power of two the S_HASH
// steps reduce the hash to its home slot first. One probe per cycle through the table RAM.
// One item at a time: a new item is taken in S_IDLE once the output register is free or being read.
// A clear or zero-key item registers its result in the cycle after acceptance; a clear then sweeps
// every slot of the RAM. After reset the same sweep runs before any item.
// ----------------------------------------------------------------------------
// Pointer-keyed linear probe cache
// Open-addressing memo table with linear probing, held in one synchronous RAM.
// ----------------------------------------------------------------------------
module pointer_keyed_linear_probe_cache #(
    parameter int unsigned TABLE_DEPTH = plpc_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire logic                                        s_axis_tvalid,
    output logic                                             s_axis_tready,
    // lookup_key [63:0], fill_value [127:64]
    input  wire logic [plpc_pkg::KEY_W+plpc_pkg::VAL_W-1:0]  s_axis_tdata,
    // req_type [0]
    input  wire logic                                        s_axis_tuser,
    output logic                                             m_axis_tvalid,
    input  wire logic                                        m_axis_tready,
    // result_value [63:0]
    output logic [plpc_pkg::VAL_W-1:0]                       m_axis_tdata,
    // value_present [0], was_hit [1], was_stored [2], table_full [3]
    output logic [plpc_pkg::FLAGS_W-1:0]                     m_axis_tuser
);
    import plpc_pkg::*;

    localparam int unsigned SW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW      = $clog2(TABLE_DEPTH + 1);
    localparam bit          IS_POW2 = ((1 << SW) == TABLE_DEPTH);
    localparam int unsigned STEP_W  = $clog2(HASH_STEPS);

    // For other depths (up to 4096) the hash bytes are summed with their weights modulo the
    // depth, and the sum is reduced by an exact reciprocal multiplication.
    localparam int unsigned SUM_W   = SW + 8 + $clog2(HASH_BYTES);
    localparam int unsigned RED_SH  = SUM_W + SW;
    localparam int unsigned RECIP_W = SUM_W + 2;
    localparam int unsigned QUOT_W  = SUM_W - SW + 1;
    localparam int unsigned PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RED_SH) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH));

    // Weight of hash byte k in the home slot sum: 2^(8k) modulo the depth.
    function automatic logic [HASH_BYTES-1:0][SW-1:0] byte_weights();
        logic [HASH_BYTES-1:0][SW-1:0] w;
        for (int unsigned k = 0; k < HASH_BYTES; k++) begin
            w[k] = SW'((64'd1 << (8 * k)) % 64'(TABLE_DEPTH));
        end
        return w;
    endfunction

    localparam logic [HASH_BYTES-1:0][SW-1:0] BYTE_WEIGHT = byte_weights();

    t_state r_state, n_state;

    logic [SW-1:0]     r_slot, n_slot;
    logic [CW-1:0]     r_probes, n_probes;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [VAL_W-1:0]  r_fill, n_fill;
    logic [KEY_W-1:0]  r_hash, n_hash;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [QUOT_W-1:0] r_quot, n_quot;
    logic [STEP_W-1:0] r_step, n_step;

    logic              r_out_valid;
    logic [VAL_W-1:0]  r_out_value, n_out_value;
    t_flags            r_out_flags, n_out_flags;
    logic              load_out;

    logic [ENTRY_W-1:0] r_mem [TABLE_DEPTH];
    t_entry             r_rd;
    logic               mem_rd_en;
    logic [SW-1:0]      mem_rd_addr;
    logic               mem_we;
    logic [SW-1:0]      mem_waddr;
    t_entry             mem_wdata;

    logic              in_accept;
    logic              req_clear;
    logic [KEY_W-1:0]  in_key;
    logic [VAL_W-1:0]  in_fill;
    logic [KEY_W-1:0]  in_hash;
    logic [SW-1:0]     slot_next;
    logic              last_slot;
    logic              last_probe;
    logic              last_step;
    logic              probe_hit;
    logic              probe_empty;
    logic [SUM_W-1:0]  hash_sum;
    logic [PROD_W-1:0] recip_prod;
    logic [SUM_W-1:0]  slot_rem;

    assign in_key    = s_axis_tdata[KEY_W-1:0];
    assign in_fill   = s_axis_tdata[KEY_W+VAL_W-1:KEY_W];
    assign req_clear = (s_axis_tuser == REQ_CLEAR);
    assign in_hash   = (in_key >> HASH_SHIFT_LO) ^ (in_key >> HASH_SHIFT_HI);

    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign last_slot  = (r_slot == SW'(TABLE_DEPTH - 1));
    assign slot_next  = last_slot ? '0 : r_slot + SW'(1);
    assign last_probe = (r_probes == CW'(TABLE_DEPTH - 1));
    assign last_step  = (r_step == STEP_W'(HASH_STEPS - 1));
    assign probe_hit   = r_rd.used && (r_rd.key == r_key);
    assign probe_empty = !r_rd.used;

    // The weighted byte sum keeps the hash's value modulo the depth in a short word.
    always_comb begin
        hash_sum = '0;
        for (int unsigned k = 0; k < HASH_BYTES; k++) begin
            hash_sum = hash_sum + SUM_W'(r_hash[8*k +: 8]) * SUM_W'(BYTE_WEIGHT[k]);
        end
    end

    assign recip_prod = PROD_W'(r_sum) * PROD_W'(RECIP);
    assign slot_rem   = r_sum - SUM_W'(r_quot) * SUM_W'(TABLE_DEPTH);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (last_slot) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    if (req_clear) begin
                        n_state = S_CLEAR;
                    end else if (in_key == '0) begin
                        n_state = S_IDLE;
                    end else if (IS_POW2) begin
                        n_state = S_ISSUE;
                    end else begin
                        n_state = S_HASH;
                    end
                end
            end
            S_HASH: begin
                if (last_step) begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (probe_hit || probe_empty || last_probe) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_slot      = r_slot;
        n_probes    = r_probes;
        n_key       = r_key;
        n_fill      = r_fill;
        n_hash      = r_hash;
        n_sum       = r_sum;
        n_quot      = r_quot;
        n_step      = r_step;
        load_out    = 1'b0;
        n_out_value = '0;
        n_out_flags = '0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = r_slot;
        mem_we      = 1'b0;
        mem_waddr   = r_slot;
        mem_wdata   = '0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                n_slot = slot_next;
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_key    = in_key;
                    n_fill   = in_fill;
                    n_hash   = in_hash;
                    n_step   = '0;
                    n_probes = '0;
                    n_slot   = IS_POW2 ? in_hash[SW-1:0] : '0;
                    // Clear and zero-key items answer with all-zero fields at once.
                    if (req_clear || (in_key == '0)) begin
                        load_out = 1'b1;
                        n_slot   = '0;
                    end
                end
            end
            S_HASH: begin
                n_step = r_step + STEP_W'(1);
                // First the byte sum, then the quotient, then the remainder as home slot.
                if (r_step == '0) begin
                    n_sum = hash_sum;
                end else begin
                    n_quot = recip_prod[RED_SH +: QUOT_W];
                end
                if (last_step) begin
                    n_slot = slot_rem[SW-1:0];
                end
            end
            S_ISSUE: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = r_slot;
            end
            S_CHECK: begin
                if (probe_hit) begin
                    load_out                  = 1'b1;
                    n_out_value               = r_rd.value;
                    n_out_flags.was_hit       = 1'b1;
                    n_out_flags.value_present = (r_rd.value != '0);
                end else if (probe_empty) begin
                    load_out                  = 1'b1;
                    n_out_value               = r_fill;
                    n_out_flags.was_stored    = 1'b1;
                    n_out_flags.value_present = (r_fill != '0);
                    mem_we                    = 1'b1;
                    mem_wdata.used            = 1'b1;
                    mem_wdata.key             = r_key;
                    mem_wdata.value           = r_fill;
                end else if (last_probe) begin
                    load_out                  = 1'b1;
                    n_out_value               = r_fill;
                    n_out_flags.table_full    = 1'b1;
                    n_out_flags.value_present = (r_fill != '0);
                end else begin
                    // Occupied by another key: read the following slot next cycle.
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = slot_next;
                    n_slot      = slot_next;
                    n_probes    = r_probes + CW'(1);
                end
            end
            default: begin
                n_slot = r_slot;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_rd_en) begin
            r_rd <= r_mem[mem_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_slot      <= '0;
            r_probes    <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_slot   <= n_slot;
            r_probes <= n_probes;
            r_step   <= n_step;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_fill <= n_fill;
        r_hash <= n_hash;
        r_sum  <= n_sum;
        r_quot <= n_quot;
        if (load_out) begin
            r_out_value <= n_out_value;
            r_out_flags <= n_out_flags;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_value;
    assign m_axis_tuser  = r_out_flags;

endmodule : pointer_keyed_linear_probe_cache
`default_nettype wire

[verif/pointer_keyed_linear_probe_cache_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pointer-keyed linear probe cache testbench
// Drives lookup, zero-key and clear items into the cache and compares every result
// item with a behavioral copy of the probing table or the expected fields of a directed
// row. A short table of directed items comes first, then random traffic with
// filled-table episodes, under several patterns of sender gaps and receiver back-pressure.
// ----------------------------------------------------------------------------
module pointer_keyed_linear_probe_cache_test;

    import plpc_pkg::*;

    localparam int unsigned DEPTH        = TABLE_DEPTH_DEF;
    localparam int unsigned RANDOM_ITEMS = 1300;
    localparam int unsigned POOL_SIZE    = 48;
    localparam int          WATCHDOG_NS  = 60_000_000;

    typedef enum int unsigned {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        t_flags           flags;
    } lookup_result_t;

    typedef struct {
        logic             req;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] fill;
        bit               typed;
        logic [VAL_W-1:0] exp_value;
        t_flags           exp_flags;
    } stim_row_t;

    localparam t_flags FLAGS_ZERO     = '{table_full: 1'b0, was_stored: 1'b0,
                                          was_hit: 1'b0, value_present: 1'b0};
    localparam t_flags FLAGS_STORE_NZ = '{table_full: 1'b0, was_stored: 1'b1,
                                          was_hit: 1'b0, value_present: 1'b1};
    localparam t_flags FLAGS_HIT_NZ   = '{table_full: 1'b0, was_stored: 1'b0,
                                          was_hit: 1'b1, value_present: 1'b1};
    localparam t_flags FLAGS_STORE_ZV = '{table_full: 1'b0, was_stored: 1'b1,
                                          was_hit: 1'b0, value_present: 1'b0};
    localparam t_flags FLAGS_HIT_ZV   = '{table_full: 1'b0, was_stored: 1'b0,
                                          was_hit: 1'b1, value_present: 1'b0};

    localparam logic [63:0] ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] KEY_H1 = 64'h0000_0000_0000_0010;
    // All three of these keys hash to the last slot, so probing wraps to slot 0.
    localparam logic [63:0] KEY_HL = 64'h0000_0000_0000_0FF0;
    localparam logic [63:0] KEY_HM = 64'h0000_0000_0000_1FE0;
    localparam logic [63:0] KEY_HT = 64'h8000_0000_0000_0FF0;

    localparam int unsigned DIR_ROWS = 18;

    stim_row_t directed_rows [DIR_ROWS] = '{
        '{REQ_LOOKUP, KEY_H1, 64'h1234, 1'b1, 64'h1234, FLAGS_STORE_NZ},
        '{REQ_LOOKUP, KEY_H1, 64'h9999, 1'b1, 64'h1234, FLAGS_HIT_NZ},
        '{REQ_LOOKUP, 64'h0, ONES, 1'b1, 64'h0, FLAGS_ZERO},
        '{REQ_CLEAR, ONES, ONES, 1'b1, 64'h0, FLAGS_ZERO},
        '{REQ_LOOKUP, KEY_H1, 64'h5555, 1'b1, 64'h5555, FLAGS_STORE_NZ},
        '{REQ_LOOKUP, ONES, ONES, 1'b1, ONES, FLAGS_STORE_NZ},
        '{REQ_LOOKUP, ONES, 64'h0, 1'b1, ONES, FLAGS_HIT_NZ},
        '{REQ_LOOKUP, KEY_HL, 64'h0, 1'b1, 64'h0, FLAGS_STORE_ZV},
        '{REQ_LOOKUP, KEY_HL, 64'h7, 1'b1, 64'h0, FLAGS_HIT_ZV},
        '{REQ_LOOKUP, KEY_HM, 64'h8000_0000_0000_0001, 1'b0, 64'h0, FLAGS_ZERO},
        '{REQ_LOOKUP, KEY_HT, 64'hFFFF_0000_FFFF_0000, 1'b0, 64'h0, FLAGS_ZERO},
        '{REQ_LOOKUP, KEY_HM, 64'h0, 1'b0, 64'h0, FLAGS_ZERO},
        '{REQ_LOOKUP, KEY_HT, 64'h1, 1'b0, 64'h0, FLAGS_ZERO},
        '{REQ_LOOKUP, 64'h0, 64'h0, 1'b1, 64'h0, FLAGS_ZERO},
        '{REQ_CLEAR, 64'h0, 64'h0, 1'b1, 64'h0, FLAGS_ZERO},
        '{REQ_LOOKUP, KEY_HL, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1,
          64'hAAAA_AAAA_AAAA_AAAA, FLAGS_STORE_NZ},
        '{REQ_LOOKUP, KEY_HM, 64'h5555_5555_5555_5555, 1'b0, 64'h0, FLAGS_ZERO},
        '{REQ_CLEAR, 64'h1, 64'h0, 1'b1, 64'h0, FLAGS_ZERO}
    };

    bit                        i_clk;
    logic                      i_rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [KEY_W+VAL_W-1:0]    s_axis_tdata;
    logic                      s_axis_tuser;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [VAL_W-1:0]          m_axis_tdata;
    logic [FLAGS_W-1:0]        m_axis_tuser;

    // Behavioral copy of the table.
    bit                        cache_used [DEPTH];
    logic [KEY_W-1:0]          cache_key  [DEPTH];
    logic [VAL_W-1:0]          cache_val  [DEPTH];
    int unsigned               occupied;

    lookup_result_t            pending_results [$];
    logic [KEY_W-1:0]          recent_keys [$];
    logic [7:0]                hot_slots [3] = '{8'hFF, 8'h00, 8'h80};
    idle_mode_t                idle_mode;
    int unsigned               err_count;

    pointer_keyed_linear_probe_cache u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(WATCHDOG_NS);
        $display("pointer_keyed_linear_probe_cache_test: errors");
        $finish;
    end

    function automatic lookup_result_t predict_lookup(logic req, logic [KEY_W-1:0] key,
                                                      logic [VAL_W-1:0] fill);
        lookup_result_t res;
        logic [63:0]    hash;
        int unsigned    slot;
        bit             done;
        res  = '0;
        done = 1'b0;
        if (req == REQ_CLEAR) begin
            for (int i = 0; i < DEPTH; i++) cache_used[i] = 1'b0;
            occupied = 0;
        end else if (key != '0) begin
            hash = (key >> HASH_SHIFT_LO) ^ (key >> HASH_SHIFT_HI);
            slot = int'(hash % 64'(DEPTH));
            for (int n = 0; n < DEPTH && !done; n++) begin
                if (cache_used[slot]) begin
                    if (cache_key[slot] == key) begin
                        res.value         = cache_val[slot];
                        res.flags.was_hit = 1'b1;
                        done              = 1'b1;
                    end
                end else begin
                    cache_used[slot]     = 1'b1;
                    cache_key[slot]      = key;
                    cache_val[slot]      = fill;
                    occupied++;
                    res.value            = fill;
                    res.flags.was_stored = 1'b1;
                    done                 = 1'b1;
                end
                slot = (slot + 1 == DEPTH) ? 0 : slot + 1;
            end
            if (!done) begin
                res.value            = fill;
                res.flags.table_full = 1'b1;
            end
        end
        res.flags.value_present = (res.value != '0);
        return res;
    endfunction

    function automatic bit sender_idles();
        if (idle_mode == IDLE_SENDER) return $urandom_range(99) < 84;
        if (idle_mode == IDLE_BOTH) return $urandom_range(99) < 6;
        return 1'b0;
    endfunction

    function automatic bit receiver_stalls();
        if (idle_mode == IDLE_RECEIVER) return $urandom_range(99) < 84;
        if (idle_mode == IDLE_BOTH) return $urandom_range(99) < 6;
        return 1'b0;
    endfunction

    function automatic logic [VAL_W-1:0] pick_fill();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) return '0;
        if (r < 15) return '1;
        return {$urandom(), $urandom()};
    endfunction

    // A random key whose home slot is the given one.
    function automatic logic [KEY_W-1:0] key_for_slot(logic [7:0] slot);
        logic [KEY_W-1:0] k;
        k       = {$urandom(), $urandom()};
        k[11:4] = slot ^ k[19:12];
        return k;
    endfunction

    function automatic logic [KEY_W-1:0] pick_known_key();
        if (recent_keys.size() == 0) return {$urandom(), $urandom()};
        return recent_keys[$urandom_range(recent_keys.size() - 1)];
    endfunction

    function automatic void remember_key(logic [KEY_W-1:0] k);
        recent_keys.push_back(k);
        if (recent_keys.size() > POOL_SIZE) void'(recent_keys.pop_front());
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(logic req, logic [KEY_W-1:0] key, logic [VAL_W-1:0] fill,
                             lookup_result_t expected);
        while (sender_idles()) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = req;
        s_axis_tdata  = {fill, key};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(expected);
        @(negedge i_clk);
    endtask

    task automatic send_lookup(logic [KEY_W-1:0] key, logic [VAL_W-1:0] fill);
        send_item(REQ_LOOKUP, key, fill, predict_lookup(REQ_LOOKUP, key, fill));
    endtask

    // Fills every slot, probes the full table with hits, misses and zero keys,
    // then empties it again.
    task automatic fill_table_and_probe();
        logic [KEY_W-1:0] key;
        int unsigned      r;
        while (occupied < DEPTH) begin
            key = {$urandom(), $urandom()};
            remember_key(key);
            send_lookup(key, pick_fill());
        end
        repeat (16) begin
            r = $urandom_range(9);
            if (r < 4) key = pick_known_key();
            else if (r < 9) key = {$urandom(), $urandom()};
            else key = '0;
            send_lookup(key, pick_fill());
        end
        send_item(REQ_CLEAR, '0, '0, predict_lookup(REQ_CLEAR, '0, '0));
    endtask

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_axis_tready = !receiver_stalls();
        end
    end

    always @(posedge i_clk) begin : check_result
        lookup_result_t exp_res;
        t_flags         got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_flags'(m_axis_tuser);
            if (pending_results.size() == 0) begin
                $error("result item with nothing expected: result_value %0h", m_axis_tdata);
                err_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (m_axis_tdata !== exp_res.value) begin
                    $error("result_value: expected %0h, got %0h", exp_res.value, m_axis_tdata);
                    err_count++;
                end
                if (got.value_present !== exp_res.flags.value_present) begin
                    $error("value_present: expected %0b, got %0b",
                           exp_res.flags.value_present, got.value_present);
                    err_count++;
                end
                if (got.was_hit !== exp_res.flags.was_hit) begin
                    $error("was_hit: expected %0b, got %0b", exp_res.flags.was_hit, got.was_hit);
                    err_count++;
                end
                if (got.was_stored !== exp_res.flags.was_stored) begin
                    $error("was_stored: expected %0b, got %0b",
                           exp_res.flags.was_stored, got.was_stored);
                    err_count++;
                end
                if (got.table_full !== exp_res.flags.table_full) begin
                    $error("table_full: expected %0b, got %0b",
                           exp_res.flags.table_full, got.table_full);
                    err_count++;
                end
            end
        end
    end

    initial begin : stimulus
        lookup_result_t   predicted;
        logic [KEY_W-1:0] key;
        int unsigned      r;
        err_count     = 0;
        occupied      = 0;
        idle_mode     = IDLE_NONE;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = REQ_LOOKUP;
        s_axis_tdata  = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            predicted = predict_lookup(directed_rows[i].req, directed_rows[i].key,
                                       directed_rows[i].fill);
            if (directed_rows[i].typed) begin
                predicted.value = directed_rows[i].exp_value;
                predicted.flags = directed_rows[i].exp_flags;
            end
            send_item(directed_rows[i].req, directed_rows[i].key, directed_rows[i].fill,
                      predicted);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idle_mode = idle_mode_t'((n * 4) / RANDOM_ITEMS);
            if (n == 100 || n == 700) fill_table_and_probe();
            r = $urandom_range(99);
            if (r < 2) begin
                // Key and fill are don't-care on a clear, so they carry noise.
                key = {$urandom(), $urandom()};
                send_item(REQ_CLEAR, key, pick_fill(), predict_lookup(REQ_CLEAR, key, '0));
            end else if (r < 5) begin
                send_lookup('0, pick_fill());
            end else if (r < 45) begin
                send_lookup(pick_known_key(), pick_fill());
            end else if (r < 65) begin
                key = key_for_slot(hot_slots[$urandom_range(2)]);
                remember_key(key);
                send_lookup(key, pick_fill());
            end else begin
                key = {$urandom(), $urandom()};
                remember_key(key);
                send_lookup(key, pick_fill());
            end
        end
        s_axis_tvalid = 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DEPTH + 24) @(posedge i_clk);
        if (err_count == 0) begin
            $display("pointer_keyed_linear_probe_cache_test: clean");
        end else begin
            $display("pointer_keyed_linear_probe_cache_test: errors");
        end
        $finish;
    end

endmodule

[pointer_keyed_linear_probe_cache.f]
hw/rtl/plpc_pkg.sv
hw/rtl/pointer_keyed_linear_probe_cache.sv
verif/pointer_keyed_linear_probe_cache_test.sv
